// ----- rtl/ter_pkg.sv -----
// Package for the triangle edge rasterizer: sizes, command codes, status codes,
// controller states. No dependencies.
package ter_pkg;

    localparam int SCREEN_WIDTH  = 160;
    localparam int SCREEN_HEIGHT = 120;
    localparam int FRAME_PIXELS  = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int ADDR_W        = $clog2(FRAME_PIXELS);
    localparam int XW            = $clog2(SCREEN_WIDTH);
    localparam int YW            = $clog2(SCREEN_HEIGHT);
    localparam int EW            = 26;  // edge value width: 13x13 product sums plus sign

    typedef enum logic [1:0] {
        REQ_DRAW  = 2'd0,
        REQ_CLEAR = 2'd1,
        REQ_READ  = 2'd2,
        REQ_NOP   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_DEGEN    = 2'd1,
        ST_OFFSCR   = 2'd2,
        ST_RESERVED = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_AREA,
        S_SETUP,
        S_WALK,
        S_CLEAR,
        S_READ,
        S_RDWAIT,
        S_OUT
    } state_t;

endpackage

// ----- rtl/ter_ram.sv -----
// Generic single-port RAM with registered read.
// No dependencies.
module ter_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write or read one entry a cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ----- rtl/triangle_edge_rasterizer_unit.sv -----
// Triangle edge rasterizer top level: controller, edge walker, frame memory.
// Depends on ter_pkg and ter_ram.
//
// Usage: commands enter on the s_axis channel, one result word per command
// leaves on m_axis. Commands: draw triangle, clear frame, read pixel.
// The frame (160x120 bytes) lives in one single-port RAM; the walker visits
// one pixel of the clipped bounding box per cycle. A draw passes through the area,
// setup and walk states; a degenerate or off-screen draw ends after setup. A clear
// writes the frame one entry a cycle, a read passes through the read and read-wait
// states, an out-of-range read ends after the read state, and a no-op goes straight out.
// Only one command is in work at a time; s_axis_tready is high only while idle,
// from the cycle after the result word is taken, so a new command is not accepted
// before the result of the last one has been taken.
// The result sits in an output register until m_axis_tready takes it; a stall
// on m_axis holds the block and keeps s_axis_tready low.
// Reset clears the controller only; frame contents are undefined until a
// clear or a draw writes them.
module triangle_edge_rasterizer_unit
    import ter_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: req_type[1:0], vert0_x[13:2], vert0_y[25:14], vert1_x[37:26],
    // vert1_y[49:38], vert2_x[61:50], vert2_y[73:62], fill_color[81:74],
    // read_index[96:82], zero [103:97]
    input  logic [103:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: pixel_value[7:0], draw_status[9:8], zero [15:10]
    output logic [15:0]  m_axis_tdata
);

    state_t state_reg, state_next;

    // command payload registers
    logic signed [12:0] x0_reg, y0_reg, x1_reg, y1_reg, x2_reg, y2_reg;
    logic signed [12:0] x0_next, y0_next, x1_next, y1_next, x2_next, y2_next;
    logic [7:0]         color_reg, color_next;
    logic [14:0]        ridx_reg, ridx_next;
    logic signed [EW-1:0] area_reg, area_next;

    // walker registers
    logic [XW-1:0] minx_reg, minx_next, maxx_reg, maxx_next, px_reg, px_next;
    logic [YW-1:0] maxy_reg, maxy_next, py_reg, py_next;
    logic [ADDR_W-1:0] addr_reg, addr_next, row_reg, row_next;
    logic signed [EW-1:0] w0_reg, w1_reg, w2_reg, w0_next, w1_next, w2_next;
    logic signed [EW-1:0] r0_reg, r1_reg, r2_reg, r0_next, r1_next, r2_next;
    logic signed [13:0] a0_reg, a1_reg, a2_reg, b0_reg, b1_reg, b2_reg;
    logic signed [13:0] a0_next, a1_next, a2_next, b0_next, b1_next, b2_next;

    // output word
    logic [7:0] pix_reg, pix_next;
    status_t    sts_reg, sts_next;

    // memory port
    logic              mem_we;
    logic [ADDR_W-1:0] mem_addr;
    logic [7:0]        mem_rdata;

    ter_ram #(.WIDTH(8), .DEPTH(FRAME_PIXELS)) u_frame (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (color_reg),
        .rdata (mem_rdata)
    );

    // setup helpers (combinational on registered vertices)
    logic signed [12:0] sx1, sy1, sx2, sy2;
    logic signed [12:0] bminx, bminy, bmaxx, bmaxy;
    logic signed [12:0] cminx, cminy, cmaxx, cmaxy;
    logic signed [13:0] e0a, e0b, e1a, e1b, e2a, e2b;
    logic signed [EW-1:0] ev0, ev1, ev2;
    logic signed [13:0] dx0, dy0, dx1, dy1, dx2, dy2;
    logic tl0, tl1, tl2;
    logic box_empty;

    always_comb
    begin
        // winding swap
        if (area_reg < 0)
        begin
            sx1 = x2_reg; sy1 = y2_reg; sx2 = x1_reg; sy2 = y1_reg;
        end
        else
        begin
            sx1 = x1_reg; sy1 = y1_reg; sx2 = x2_reg; sy2 = y2_reg;
        end
        bminx = x0_reg; if (sx1 < bminx) bminx = sx1; if (sx2 < bminx) bminx = sx2;
        bminy = y0_reg; if (sy1 < bminy) bminy = sy1; if (sy2 < bminy) bminy = sy2;
        bmaxx = x0_reg; if (sx1 > bmaxx) bmaxx = sx1; if (sx2 > bmaxx) bmaxx = sx2;
        bmaxy = y0_reg; if (sy1 > bmaxy) bmaxy = sy1; if (sy2 > bmaxy) bmaxy = sy2;
        cminx = (bminx < 0) ? 13'sd0 : bminx;
        cminy = (bminy < 0) ? 13'sd0 : bminy;
        cmaxx = (bmaxx > 13'(SCREEN_WIDTH - 1)) ? 13'(SCREEN_WIDTH - 1) : bmaxx;
        cmaxy = (bmaxy > 13'(SCREEN_HEIGHT - 1)) ? 13'(SCREEN_HEIGHT - 1) : bmaxy;
        box_empty = (cminx > cmaxx) || (cminy > cmaxy);
        // edge deltas: v1->v2, v2->v0, v0->v1
        dx0 = 14'(sx2) - 14'(sx1);    dy0 = 14'(sy2) - 14'(sy1);
        dx1 = 14'(x0_reg) - 14'(sx2); dy1 = 14'(y0_reg) - 14'(sy2);
        dx2 = 14'(sx1) - 14'(x0_reg); dy2 = 14'(sy1) - 14'(y0_reg);
        tl0 = (dy0 == 0) ? (dx0 > 0) : (dy0 < 0);
        tl1 = (dy1 == 0) ? (dx1 > 0) : (dy1 < 0);
        tl2 = (dy2 == 0) ? (dx2 > 0) : (dy2 < 0);
        // edge values at (cminx, cminy)
        e0a = 14'(cminy) - 14'(sy1);    e0b = 14'(cminx) - 14'(sx1);
        e1a = 14'(cminy) - 14'(sy2);    e1b = 14'(cminx) - 14'(sx2);
        e2a = 14'(cminy) - 14'(y0_reg); e2b = 14'(cminx) - 14'(x0_reg);
        ev0 = EW'(dx0 * e0a) - EW'(dy0 * e0b) - EW'(!tl0);
        ev1 = EW'(dx1 * e1a) - EW'(dy1 * e1b) - EW'(!tl1);
        ev2 = EW'(dx2 * e2a) - EW'(dy2 * e2b) - EW'(!tl2);
    end

    // twice signed area
    logic signed [13:0] ad1x, ad1y, ad2x, ad2y;
    assign ad1x = 14'(x1_reg) - 14'(x0_reg);
    assign ad1y = 14'(y1_reg) - 14'(y0_reg);
    assign ad2x = 14'(x2_reg) - 14'(x0_reg);
    assign ad2y = 14'(y2_reg) - 14'(y0_reg);

    logic px_covered;
    assign px_covered = !w0_reg[EW-1] && !w1_reg[EW-1] && !w2_reg[EW-1];

    // state register and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x0_reg <= x0_next; y0_reg <= y0_next; x1_reg <= x1_next;
        y1_reg <= y1_next; x2_reg <= x2_next; y2_reg <= y2_next;
        color_reg <= color_next; ridx_reg <= ridx_next; area_reg <= area_next;
        minx_reg <= minx_next; maxx_reg <= maxx_next; px_reg <= px_next;
        maxy_reg <= maxy_next; py_reg <= py_next;
        addr_reg <= addr_next; row_reg <= row_next;
        w0_reg <= w0_next; w1_reg <= w1_next; w2_reg <= w2_next;
        r0_reg <= r0_next; r1_reg <= r1_next; r2_reg <= r2_next;
        a0_reg <= a0_next; a1_reg <= a1_next; a2_reg <= a2_next;
        b0_reg <= b0_next; b1_reg <= b1_next; b2_reg <= b2_next;
        pix_reg <= pix_next; sts_reg <= sts_next;
    end

    // next state and outputs
    always_comb
    begin
        state_next = state_reg;
        x0_next = x0_reg; y0_next = y0_reg; x1_next = x1_reg;
        y1_next = y1_reg; x2_next = x2_reg; y2_next = y2_reg;
        color_next = color_reg; ridx_next = ridx_reg; area_next = area_reg;
        minx_next = minx_reg; maxx_next = maxx_reg; px_next = px_reg;
        maxy_next = maxy_reg; py_next = py_reg;
        addr_next = addr_reg; row_next = row_reg;
        w0_next = w0_reg; w1_next = w1_reg; w2_next = w2_reg;
        r0_next = r0_reg; r1_next = r1_reg; r2_next = r2_reg;
        a0_next = a0_reg; a1_next = a1_reg; a2_next = a2_reg;
        b0_next = b0_reg; b1_next = b1_reg; b2_next = b2_reg;
        pix_next = pix_reg; sts_next = sts_reg;
        mem_we = 1'b0;
        mem_addr = addr_reg;
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    x0_next = 13'(signed'(s_axis_tdata[13:2]));
                    y0_next = 13'(signed'(s_axis_tdata[25:14]));
                    x1_next = 13'(signed'(s_axis_tdata[37:26]));
                    y1_next = 13'(signed'(s_axis_tdata[49:38]));
                    x2_next = 13'(signed'(s_axis_tdata[61:50]));
                    y2_next = 13'(signed'(s_axis_tdata[73:62]));
                    color_next = s_axis_tdata[81:74];
                    ridx_next = s_axis_tdata[96:82];
                    pix_next = 8'd0;
                    sts_next = ST_DONE;
                    addr_next = '0;
                    unique case (req_t'(s_axis_tdata[1:0]))
                        REQ_DRAW:  state_next = S_AREA;
                        REQ_CLEAR: state_next = S_CLEAR;
                        REQ_READ:  state_next = S_READ;
                        REQ_NOP:   state_next = S_OUT;
                        default:   state_next = S_OUT;
                    endcase
                end
            end
            S_AREA:
            begin
                area_next = EW'(ad1x * ad2y) - EW'(ad1y * ad2x);
                state_next = S_SETUP;
            end
            S_SETUP:
            begin
                if (area_reg == 0)
                begin
                    sts_next = ST_DEGEN;
                    state_next = S_OUT;
                end
                else if (box_empty)
                begin
                    sts_next = ST_OFFSCR;
                    state_next = S_OUT;
                end
                else
                begin
                    minx_next = XW'(cminx); maxx_next = XW'(cmaxx);
                    px_next = XW'(cminx); py_next = YW'(cminy);
                    maxy_next = YW'(cmaxy);
                    row_next = ADDR_W'(cminy) * ADDR_W'(SCREEN_WIDTH);
                    addr_next = ADDR_W'(cminy) * ADDR_W'(SCREEN_WIDTH)
                                + ADDR_W'(cminx);
                    w0_next = ev0; w1_next = ev1; w2_next = ev2;
                    r0_next = ev0; r1_next = ev1; r2_next = ev2;
                    // step in x subtracts dy, step in y adds dx
                    a0_next = dy0; a1_next = dy1; a2_next = dy2;
                    b0_next = dx0; b1_next = dx1; b2_next = dx2;
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                mem_we = px_covered;
                if (px_reg == maxx_reg)
                begin
                    if (py_reg == maxy_reg)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        py_next = py_reg + 1'b1;
                        px_next = minx_reg;
                        row_next = row_reg + ADDR_W'(SCREEN_WIDTH);
                        addr_next = row_reg + ADDR_W'(SCREEN_WIDTH) + ADDR_W'(minx_reg);
                        r0_next = r0_reg + EW'(b0_reg);
                        r1_next = r1_reg + EW'(b1_reg);
                        r2_next = r2_reg + EW'(b2_reg);
                        w0_next = r0_reg + EW'(b0_reg);
                        w1_next = r1_reg + EW'(b1_reg);
                        w2_next = r2_reg + EW'(b2_reg);
                    end
                end
                else
                begin
                    px_next = px_reg + 1'b1;
                    addr_next = addr_reg + 1'b1;
                    w0_next = w0_reg - EW'(a0_reg);
                    w1_next = w1_reg - EW'(a1_reg);
                    w2_next = w2_reg - EW'(a2_reg);
                end
            end
            S_CLEAR:
            begin
                mem_we = 1'b1;
                addr_next = addr_reg + 1'b1;
                if (addr_reg == ADDR_W'(FRAME_PIXELS - 1))
                begin
                    state_next = S_OUT;
                end
            end
            S_READ:
            begin
                mem_addr = ADDR_W'(ridx_reg);
                if (ridx_reg < 15'(FRAME_PIXELS))
                begin
                    state_next = S_RDWAIT;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_RDWAIT:
            begin
                pix_next = mem_rdata;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                m_axis_tvalid = 1'b1;
                if (m_axis_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_axis_tdata = {6'd0, sts_reg, pix_reg};

`ifndef SYNTHESIS
    // memory writes only while drawing or clearing
    a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_WALK || state_reg == S_CLEAR))
        else $error("frame write outside draw or clear");
    // walker stays inside the clipped box
    a_walk_box: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WALK |-> (px_reg <= maxx_reg && py_reg <= maxy_reg))
        else $error("walker left bounding box");
    // result held until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result dropped while stalled");
    // no new command while a result waits
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input open while result pending");
    // walker address tracks position
    a_addr: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WALK |-> addr_reg == row_reg + ADDR_W'(px_reg))
        else $error("walker address mismatch");
`endif

endmodule

// ----- tb/triangle_edge_rasterizer_unit_tb.sv -----
// Self-checking testbench for triangle_edge_rasterizer_unit: draw, clear, read and no-op commands
// on the stream ports, checked against a behavioral frame model kept in the bench.
// Depends on ter_pkg and the RTL of the block.
module triangle_edge_rasterizer_unit_tb;
    import ter_pkg::*;

    typedef struct packed {
        logic [14:0] read_index;
        logic [7:0]  fill_color;
        logic signed [11:0] v2y, v2x, v1y, v1x, v0y, v0x;
        req_t        req;
    } cmd_word_t;

    typedef struct {
        cmd_word_t cmd;
        bit        fixed;   // expected value typed in below
        logic [7:0] pix;
        status_t   st;
    } stim_row_t;

    typedef struct packed {
        logic [7:0] pix;
        status_t    st;
    } pixel_result_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [15:0]  m_axis_tdata;

    triangle_edge_rasterizer_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    logic [7:0]    frame_shadow [FRAME_PIXELS];
    pixel_result_t pending_results [$];
    stim_row_t     directed_rows [$];
    int            mismatch_count;
    int            idle_cycles;
    bit            stim_done;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint edge_fn(longint ax, longint ay, longint bx, longint by,
                                       longint px, longint py);
        return (bx - ax) * (py - ay) - (by - ay) * (px - ax);
    endfunction

    function automatic longint tl_bias(longint ax, longint ay, longint bx, longint by);
        bit top_left;
        top_left = (ay == by) ? (bx > ax) : (by < ay);
        return top_left ? 0 : -1;
    endfunction

    // predicted result of one command, frame shadow updated in place
    function automatic pixel_result_t raster_predict(cmd_word_t c);
        pixel_result_t r;
        longint x0, y0, x1, y1, x2, y2, t, area;
        longint mnx, mny, mxx, mxy, b0, b1, b2;
        r.pix = 8'd0;
        r.st  = ST_DONE;
        case (c.req)
            REQ_DRAW:
            begin
                x0 = c.v0x; y0 = c.v0y; x1 = c.v1x; y1 = c.v1y; x2 = c.v2x; y2 = c.v2y;
                area = edge_fn(x0, y0, x1, y1, x2, y2);
                if (area == 0)
                begin
                    r.st = ST_DEGEN;
                    return r;
                end
                if (area < 0)
                begin
                    t = x1; x1 = x2; x2 = t;
                    t = y1; y1 = y2; y2 = t;
                end
                mnx = x0; if (x1 < mnx) mnx = x1; if (x2 < mnx) mnx = x2;
                mny = y0; if (y1 < mny) mny = y1; if (y2 < mny) mny = y2;
                mxx = x0; if (x1 > mxx) mxx = x1; if (x2 > mxx) mxx = x2;
                mxy = y0; if (y1 > mxy) mxy = y1; if (y2 > mxy) mxy = y2;
                if (mnx < 0) mnx = 0;
                if (mny < 0) mny = 0;
                if (mxx > SCREEN_WIDTH - 1) mxx = SCREEN_WIDTH - 1;
                if (mxy > SCREEN_HEIGHT - 1) mxy = SCREEN_HEIGHT - 1;
                if (mnx > mxx || mny > mxy)
                begin
                    r.st = ST_OFFSCR;
                    return r;
                end
                b0 = tl_bias(x1, y1, x2, y2);
                b1 = tl_bias(x2, y2, x0, y0);
                b2 = tl_bias(x0, y0, x1, y1);
                for (longint y = mny; y <= mxy; y++)
                    for (longint x = mnx; x <= mxx; x++)
                        if (edge_fn(x1, y1, x2, y2, x, y) + b0 >= 0 &&
                            edge_fn(x2, y2, x0, y0, x, y) + b1 >= 0 &&
                            edge_fn(x0, y0, x1, y1, x, y) + b2 >= 0)
                            frame_shadow[y * SCREEN_WIDTH + x] = c.fill_color;
            end
            REQ_CLEAR:
            begin
                foreach (frame_shadow[i]) frame_shadow[i] = c.fill_color;
            end
            REQ_READ:
                if (c.read_index < FRAME_PIXELS)
                    r.pix = frame_shadow[c.read_index];
            default: ;
        endcase
        return r;
    endfunction

    function automatic cmd_word_t make_cmd(req_t rq, int ax, int ay, int bx, int by,
                                           int cx, int cy, int col, int idx);
        cmd_word_t c;
        c.req = rq;
        c.v0x = 12'(ax); c.v0y = 12'(ay); c.v1x = 12'(bx); c.v1y = 12'(by);
        c.v2x = 12'(cx); c.v2y = 12'(cy);
        c.fill_color = 8'(col);
        c.read_index = 15'(idx);
        return c;
    endfunction

    function automatic void add_row(cmd_word_t c, bit fx, logic [7:0] p, status_t s);
        stim_row_t row;
        row.cmd = c; row.fixed = fx; row.pix = p; row.st = s;
        directed_rows.push_back(row);
    endfunction

    // small random triangle, mostly on screen, a few huge or off-screen ones
    function automatic cmd_word_t rand_draw();
        cmd_word_t c;
        int cx, cy, span;
        c = make_cmd(REQ_DRAW, 0, 0, 0, 0, 0, 0, $urandom_range(255), $urandom);
        case ($urandom_range(9))
            0:
            begin
                c.v0x = 12'($urandom); c.v0y = 12'($urandom); c.v1x = 12'($urandom);
                c.v1y = 12'($urandom); c.v2x = 12'($urandom); c.v2y = 12'($urandom);
            end
            1:
            begin
                c.v0x = 12'(-2048 + $urandom_range(100)); c.v0y = 12'($urandom_range(2047));
                c.v1x = 12'(-2048 + $urandom_range(100)); c.v1y = 12'(-$urandom_range(2048));
                c.v2x = 12'(-$urandom_range(2000, 1)); c.v2y = 12'($urandom_range(60));
            end
            default:
            begin
                cx = $urandom_range(SCREEN_WIDTH + 10) - 5;
                cy = $urandom_range(SCREEN_HEIGHT + 10) - 5;
                span = ($urandom_range(3) == 0) ? 40 : 12;
                c.v0x = 12'(cx + $urandom_range(2 * span) - span);
                c.v0y = 12'(cy + $urandom_range(2 * span) - span);
                c.v1x = 12'(cx + $urandom_range(2 * span) - span);
                c.v1y = 12'(cy + $urandom_range(2 * span) - span);
                c.v2x = 12'(cx + $urandom_range(2 * span) - span);
                c.v2y = 12'(cy + $urandom_range(2 * span) - span);
            end
        endcase
        return c;
    endfunction

    // valid drops only when a gap follows; back to back keeps it high
    task automatic send_cmd(cmd_word_t c);
        int gap;
        gap = $urandom_range(11);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, c};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
    endtask

    // stimulus
    initial
    begin
        cmd_word_t c;
        pixel_result_t exp_res;
        int pick;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        stim_done     = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reads only after the frame is cleared
        add_row(make_cmd(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 8'hA5, 0), 1, 8'd0, ST_DONE);
        add_row(make_cmd(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0), 1, 8'hA5, ST_DONE);
        add_row(make_cmd(REQ_READ, 0, 0, 0, 0, 0, 0, 0, FRAME_PIXELS - 1), 1, 8'hA5, ST_DONE);
        add_row(make_cmd(REQ_READ, 0, 0, 0, 0, 0, 0, 0, FRAME_PIXELS), 1, 8'd0, ST_DONE);
        add_row(make_cmd(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 32767), 1, 8'd0, ST_DONE);
        add_row(make_cmd(REQ_NOP, -1, -1, -1, -1, -1, -1, 255, 32767), 1, 8'd0, ST_DONE);
        add_row(make_cmd(REQ_DRAW, 5, 5, 10, 10, 15, 15, 8'h11, 0), 1, 8'd0, ST_DEGEN);
        add_row(make_cmd(REQ_DRAW, -2048, -2048, -2048, 2047, 2047, -2048, 0, 0), 0, 0, ST_DONE);
        add_row(make_cmd(REQ_DRAW, 2047, 2047, 2000, 2047, 2047, 200, 8'h22, 0),
                1, 8'd0, ST_OFFSCR);
        add_row(make_cmd(REQ_DRAW, -50, -50, -10, -60, -30, -1, 8'h33, 0), 1, 8'd0, ST_OFFSCR);
        add_row(make_cmd(REQ_DRAW, 10, 10, 30, 10, 10, 30, 8'hFF, 0), 0, 0, ST_DONE);
        add_row(make_cmd(REQ_DRAW, 10, 10, 10, 30, 30, 10, 8'h44, 0), 0, 0, ST_DONE);
        add_row(make_cmd(REQ_DRAW, 0, 0, 159, 0, 0, 119, 8'h55, 0), 0, 0, ST_DONE);
        add_row(make_cmd(REQ_DRAW, 159, 0, 159, 119, 0, 119, 8'h66, 0), 0, 0, ST_DONE);
        add_row(make_cmd(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 10 * SCREEN_WIDTH + 10), 0, 0, ST_DONE);
        add_row(make_cmd(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 20 * SCREEN_WIDTH + 10), 0, 0, ST_DONE);
        add_row(make_cmd(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 10 * SCREEN_WIDTH + 20), 0, 0, ST_DONE);
        add_row(make_cmd(REQ_DRAW, 100, 50, 100, 50, 100, 50, 8'h77, 0), 1, 8'd0, ST_DEGEN);

        foreach (directed_rows[i])
        begin
            c = directed_rows[i].cmd;
            exp_res = raster_predict(c);
            if (directed_rows[i].fixed)
            begin
                exp_res.pix = directed_rows[i].pix;
                exp_res.st  = directed_rows[i].st;
            end
            pending_results.push_back(exp_res);
            send_cmd(c);
        end

        // random: draws and reads of random pixels in about equal share, with occasional clears and no-ops
        for (int n = 0; n < 82; n++)
        begin
            pick = $urandom_range(19);
            if (pick < 9)
                c = rand_draw();
            else if (pick < 18)
            begin
                c = make_cmd(REQ_READ, $urandom, $urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom, $urandom_range(FRAME_PIXELS - 1));
                if ($urandom_range(7) == 0)
                    c.read_index = 15'($urandom_range(32767, FRAME_PIXELS));
            end
            else if (pick == 18)
                c = make_cmd(REQ_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom_range(255), $urandom);
            else
                c = make_cmd(REQ_NOP, $urandom, $urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom_range(255), $urandom);
            pending_results.push_back(raster_predict(c));
            send_cmd(c);
        end
        s_axis_tvalid <= 1'b0;
        stim_done <= 1'b1;
    end

    // result side: random stalls, field-by-field compare
    initial
    begin
        pixel_result_t got, want;
        int stall;
        m_axis_tready = 1'b0;
        mismatch_count = 0;
        @(posedge rst_n);
        forever
        begin
            stall = $urandom_range(11);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid) @(posedge clk);
            got.pix = m_axis_tdata[7:0];
            got.st  = status_t'(m_axis_tdata[9:8]);
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected word: pixel %0d status %0d", got.pix, got.st);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.pix !== want.pix || got.st !== want.st || m_axis_tdata[15:10] !== '0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected pixel %0d status %0d, got pixel %0d status %0d",
                                 want.pix, want.st, got.pix, got.st);
                end
            end
        end
    end

    // watchdog on handshake activity
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // end of run
    initial
    begin
        idle_cycles = 0;
        wait (stim_done && pending_results.size() == 0);
        repeat (50) @(posedge clk);
        if (mismatch_count == 0)
            $display("triangle_edge_rasterizer_unit regression: pass");
        else
            $display("triangle_edge_rasterizer_unit regression: fail");
        $finish;
    end

    initial
    begin
        wait (idle_cycles >= 100000);
        $display("triangle_edge_rasterizer_unit regression: fail");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/ter_pkg.sv
rtl/ter_ram.sv
rtl/triangle_edge_rasterizer_unit.sv
tb/triangle_edge_rasterizer_unit_tb.sv
